// ----- hdl/utf8_to_utf16_stream_decoder_assert.svh -----
// Assertion macros used by the top level of the UTF-8 to UTF-16 decoder.
`ifndef UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/u8u16_pkg.sv -----
// Types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned UNIT_W    = 16;
    localparam int unsigned PARTIAL_W = 10;
    localparam int unsigned PEND_W    = 2;

    localparam logic [UNIT_W-1:0] BOM_UNIT = 16'hFEFF;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    // Class of a byte that arrives with no continuation expected.
    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_BAD
    } t_lead;

    // One decode step's outcome, handed from the step unit to the output stage.
    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] code_unit;
        logic              bad_lead;
    } t_result;

    function automatic t_lead lead_class(input logic [BYTE_W-1:0] b);
        t_lead c;
        unique case (b[7:4]) inside
            [4'h0:4'h7]:  c = LEAD_ASCII;
            [4'hC:4'hD]:  c = LEAD_TWO;
            4'hE:         c = LEAD_THREE;
            default:      c = LEAD_BAD;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/u8u16_step.sv -----
// Sequence state and per-byte decode step of the UTF-8 to UTF-16 decoder.
module u8u16_step
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_line_first,
    output t_result           o_result
);

    logic [PEND_W-1:0]    r_pend, n_pend;
    logic [PARTIAL_W-1:0] r_partial, n_partial;
    logic                 r_seq_start, n_seq_start;

    logic [PEND_W-1:0] pend_eff;
    logic [PEND_W-1:0] pend_dec;
    logic [UNIT_W-1:0] acc;

    always_comb begin
        // a new line drops any unfinished sequence
        pend_eff    = i_line_first ? PEND_NONE : r_pend;
        pend_dec    = pend_eff - PEND_ONE;
        acc         = {r_partial, i_data_byte[5:0]};
        n_pend      = r_pend;
        n_partial   = r_partial;
        n_seq_start = r_seq_start;
        o_result    = '{emit: 1'b0, code_unit: '0, bad_lead: 1'b0};

        if (pend_eff != PEND_NONE) begin
            n_pend = pend_dec;
            if (pend_dec != PEND_NONE) begin
                n_partial = acc[PARTIAL_W-1:0];
            end else begin
                n_partial          = '0;
                o_result.emit      = !(acc == BOM_UNIT && r_seq_start);
                o_result.code_unit = acc;
            end
        end else begin
            n_pend = PEND_NONE;
            unique case (lead_class(i_data_byte))
                LEAD_ASCII: begin
                    o_result.emit      = 1'b1;
                    o_result.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, i_data_byte};
                end
                LEAD_TWO: begin
                    n_partial   = {{(PARTIAL_W-5){1'b0}}, i_data_byte[4:0]};
                    n_pend      = PEND_ONE;
                    n_seq_start = i_line_first;
                end
                LEAD_THREE: begin
                    n_partial   = {{(PARTIAL_W-4){1'b0}}, i_data_byte[3:0]};
                    n_pend      = PEND_TWO;
                    n_seq_start = i_line_first;
                end
                default: begin
                    o_result.emit     = 1'b1;
                    o_result.bad_lead = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= PEND_NONE;
            r_partial   <= '0;
            r_seq_start <= 1'b0;
        end else if (i_fire) begin
            r_pend      <= n_pend;
            r_partial   <= n_partial;
            r_seq_start <= n_seq_start;
        end
    end

endmodule

// ----- hdl/utf8_to_utf16_stream_decoder.sv -----
// Top level of the UTF-8 to UTF-16 stream decoder (basic multilingual plane).
//
//  channel   direction  tdata               tuser
//  s_axis    in         [7:0] data_byte     [0] line_first
//  m_axis    out        [15:0] code_unit    [0] bad_lead
//
// One byte per cycle sustained while m_axis accepts: an input register feeds
// the decode step and the result lands in an output register.
// Each byte gives zero or one code unit; lead and middle bytes of a sequence,
// a byte-order mark on a line start and a cut-short sequence give none.
// Synchronous active-low reset clears both valid flags and sequence state.
// A stall on m_axis holds the output register; the input register advances
// only when the output slot is free, even for a byte that gives no unit, so
// s_axis backs up only when both registers are full and the output is stalled.
module utf8_to_utf16_stream_decoder
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]        i_s_axis_tuser,   // [0] line_first
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,   // [15:0] code_unit
    output logic [0:0]        o_m_axis_tuser    // [0] bad_lead
);

`include "utf8_to_utf16_stream_decoder_assert.svh"

    // input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [UNIT_W-1:0] r_out_code;
    logic              r_out_bad;

    logic    out_free;
    logic    step_fire;
    logic    s_xfer;
    t_result step_res;

    always_comb begin
        // the output slot frees when empty or when its transfer completes
        out_free        = !r_out_valid || i_m_axis_tready;
        step_fire       = r_in_valid && out_free;
        o_s_axis_tready = !r_in_valid || out_free;
        s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

        n_in_valid = r_in_valid;
        if (s_xfer) begin
            n_in_valid = 1'b1;
        end else if (step_fire) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = step_fire && step_res.emit;
        end
    end

    u8u16_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (step_fire),
        .i_data_byte  (r_in_byte),
        .i_line_first (r_in_first),
        .o_result     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: load input on transfer, result when the step fires
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_first <= i_s_axis_tuser[0];
        end
        if (step_fire) begin
            r_out_code <= step_res.code_unit;
            r_out_bad  <= step_res.bad_lead;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_code;
    assign o_m_axis_tuser[0] = r_out_bad;

    `U8U16_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, step_fire && step_res.emit, r_out_valid, "emitted unit not registered")
    `U8U16_ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, r_out_valid && r_out_bad, r_out_code == '0, "bad lead with nonzero unit")
    `U8U16_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready, r_in_valid && r_out_valid && !i_m_axis_tready, "input stalled with free room")
    `U8U16_ASSERT_NEXT(a_drop_frees, i_clk, i_rst_n, step_fire && !step_res.emit && !s_xfer, !r_in_valid && !r_out_valid, "silent byte left stale state")

endmodule
